/* rtl/rcfb_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the RFID command frame builder.
// Depends on nothing; the controller, datapath, top level and testbench import it.
`default_nettype none

package rcfb_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  ADDR_ALL     = 8'hff;
  localparam logic [7:0]  LEN_READ     = 8'h06;
  localparam logic [7:0]  CMD_READ     = 8'h12;
  localparam logic [7:0]  LEN_WRITE    = 8'h0a;
  localparam logic [7:0]  CMD_WRITE    = 8'h10;
  localparam logic        REQ_READ     = 1'b0;
  localparam logic        REQ_WRITE    = 1'b1;
  localparam int          IDX_W        = 4;
  localparam logic [IDX_W-1:0] BODY_READ  = 4'd4;
  localparam logic [IDX_W-1:0] BODY_WRITE = 4'd8;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic final_byte;
  } dp_status_t;

  // One byte of CRC-16 with polynomial 0x1021, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[15:8] ^ b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c ^ {crc[7:0], 8'h00};
  endfunction

endpackage

`default_nettype wire

/* rtl/rcfb_if.sv */
// Valid/ready channel interfaces for request beats and frame byte beats.
// Depends on nothing.
`default_nettype none

interface rcfb_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] sector;
  logic [7:0] key_byte0;
  logic [7:0] key_byte1;
  logic [7:0] key_byte2;
  logic [7:0] key_byte3;

  modport source (output valid, req_type, sector, key_byte0, key_byte1, key_byte2, key_byte3,
                  input ready);
  modport sink (input valid, req_type, sector, key_byte0, key_byte1, key_byte2, key_byte3,
                output ready);
endinterface

interface rcfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* rtl/rcfb_ctrl.sv */
// Controller state machine: accepts a request beat and steps the datapath through its frame.
// Depends on rcfb_pkg.
`default_nettype none

module rcfb_ctrl
  import rcfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.final_byte) begin
            // The next request may be taken as the last byte leaves.
            in_ready = 1'b1;
            if (in_valid) begin
              cmd.load = 1'b1;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rcfb_datapath.sv */
// Datapath: request registers, address register, byte counter, running CRC and output register.
// Depends on rcfb_pkg.
`default_nettype none

module rcfb_datapath
  import rcfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_sector,
  input  wire logic [7:0] in_key_byte0,
  input  wire logic [7:0] in_key_byte1,
  input  wire logic [7:0] in_key_byte2,
  input  wire logic [7:0] in_key_byte3,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_tx_byte,
  output logic            out_last_byte
);

  logic [7:0]       mod_addr_r;
  logic             req_type_r;
  logic [7:0]       sector_r;
  logic [7:0]       key_r [4];
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [15:0]      crc_r;
  logic [15:0]      crc_nxt;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic [IDX_W-1:0] body_len;
  logic [7:0]       sel_byte;
  logic             in_body;
  logic             final_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_addr_r <= ADDR_ALL;
    end else if (cfg_we) begin
      mod_addr_r <= cfg_wdata;
    end
  end

  assign body_len  = (req_type_r == REQ_WRITE) ? BODY_WRITE : BODY_READ;
  assign in_body   = idx_r < body_len;
  assign final_sel = idx_r == (body_len + IDX_W'(1));

  always_comb begin
    sel_byte = crc_r[7:0];
    if (idx_r == IDX_W'(0)) begin
      sel_byte = mod_addr_r;
    end else if (idx_r == IDX_W'(1)) begin
      sel_byte = (req_type_r == REQ_WRITE) ? LEN_WRITE : LEN_READ;
    end else if (idx_r == IDX_W'(2)) begin
      sel_byte = (req_type_r == REQ_WRITE) ? CMD_WRITE : CMD_READ;
    end else if (idx_r == body_len - IDX_W'(1)) begin
      sel_byte = sector_r;
    end else if (in_body) begin
      sel_byte = key_r[2'(idx_r - IDX_W'(3))];
    end else if (idx_r == body_len) begin
      sel_byte = crc_r[15:8];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    if (cmd.load) begin
      idx_nxt = '0;
      crc_nxt = '0;
    end else if (cmd.emit) begin
      idx_nxt = idx_r + IDX_W'(1);
      if (in_body) begin
        crc_nxt = crc16_byte(crc_r, sel_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    crc_r <= crc_nxt;
    if (cmd.load) begin
      req_type_r <= in_req_type;
      sector_r   <= in_sector;
      key_r[0]   <= in_key_byte0;
      key_r[1]   <= in_key_byte1;
      key_r[2]   <= in_key_byte2;
      key_r[3]   <= in_key_byte3;
    end
    if (cmd.emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= final_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free   = !out_valid_r || out_ready;
  assign status.final_byte = final_sel;
  assign out_valid         = out_valid_r;
  assign out_tx_byte       = out_byte_r;
  assign out_last_byte     = out_last_r;

endmodule

`default_nettype wire

/* rtl/rfid_command_frame_builder.sv */
// Top level of the RFID command frame builder: joins controller and datapath to the channels.
// Depends on rcfb_pkg, rcfb_if, rcfb_ctrl and rcfb_datapath.
//
// Each accepted request beat yields one command frame sent as byte beats: six for a sector
// read, ten for a tag write, with the CRC-16 (polynomial 0x1021, initial value zero) of the
// preceding bytes in the last two and last_byte set on the final one. The running CRC advances
// one byte per cycle while the sink accepts bytes, and the next request is taken in the cycle
// its predecessor's last byte is registered. The module address register resets to 0xff and
// should be written only while no frame is in flight.
`default_nettype none

module rfid_command_frame_builder
  import rcfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  rcfb_req_if.sink        in_req,
  rcfb_byte_if.source     out_byte
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rcfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcfb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_req_type   (in_req.req_type),
    .in_sector     (in_req.sector),
    .in_key_byte0  (in_req.key_byte0),
    .in_key_byte1  (in_req.key_byte1),
    .in_key_byte2  (in_req.key_byte2),
    .in_key_byte3  (in_req.key_byte3),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_byte.valid),
    .out_ready     (out_byte.ready),
    .out_tx_byte   (out_byte.tx_byte),
    .out_last_byte (out_byte.last_byte)
  );

endmodule

`default_nettype wire

/* dv/rfid_command_frame_builder_tb.sv */
// Self-checking testbench for rfid_command_frame_builder: predicts every frame byte from each
// request beat and the module address, and compares the byte beats under random flow control.
// Depends on rtl/rcfb_pkg.sv, rtl/rcfb_if.sv and the block's RTL.
`timescale 1ns / 1ps

module rfid_command_frame_builder_tb
  import rcfb_pkg::*;
();

  typedef struct packed {
    logic       req_type;
    logic [7:0] sector;
    logic [7:0] key0;
    logic [7:0] key1;
    logic [7:0] key2;
    logic [7:0] key3;
  } frame_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  rcfb_req_if  req_ch ();
  rcfb_byte_if byte_ch ();

  rfid_command_frame_builder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_ch),
    .out_byte (byte_ch)
  );

  frame_byte_t frame_bytes_q[$];
  logic [7:0]  module_address_shadow = ADDR_ALL;
  int          mismatch_count = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int          sink_hold_cycles = 0;
  frame_byte_t want_byte;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ data[i];
      acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  function automatic void predict_frame(input frame_req_t rq);
    logic [7:0]  body[$];
    logic [15:0] crc;
    frame_byte_t fb;
    crc = 16'h0000;
    body.push_back(module_address_shadow);
    if (rq.req_type == REQ_READ) begin
      body.push_back(LEN_READ);
      body.push_back(CMD_READ);
    end else begin
      body.push_back(LEN_WRITE);
      body.push_back(CMD_WRITE);
      body.push_back(rq.key0);
      body.push_back(rq.key1);
      body.push_back(rq.key2);
      body.push_back(rq.key3);
    end
    body.push_back(rq.sector);
    foreach (body[i]) crc = crc16_step(crc, body[i]);
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
    foreach (body[i]) begin
      fb.tx_byte   = body[i];
      fb.last_byte = (i == body.size() - 1);
      frame_bytes_q.push_back(fb);
    end
  endfunction

  task automatic log_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && byte_ch.valid && byte_ch.ready) begin
      if (frame_bytes_q.size() == 0) begin
        log_failure($sformatf("unexpected beat tx_byte=%02h last_byte=%0b",
                              byte_ch.tx_byte, byte_ch.last_byte));
      end else begin
        want_byte = frame_bytes_q.pop_front();
        if (byte_ch.tx_byte !== want_byte.tx_byte ||
            byte_ch.last_byte !== want_byte.last_byte) begin
          log_failure($sformatf("tx_byte exp %02h got %02h, last_byte exp %0b got %0b",
                                want_byte.tx_byte, byte_ch.tx_byte,
                                want_byte.last_byte, byte_ch.last_byte));
        end
      end
    end
  end

  initial begin : byte_sink
    int stall;
    byte_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 7) : 0;
      if (stall > 0 || sink_hold_cycles > 0) begin
        byte_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (sink_hold_cycles > 0) begin
          @(posedge clk);
          sink_hold_cycles--;
        end
      end
      byte_ch.ready <= 1'b1;
      @(posedge clk);
      while (!byte_ch.valid) @(posedge clk);
    end
  end

  task automatic send_request(input frame_req_t rq);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= rq.req_type;
    req_ch.sector    <= rq.sector;
    req_ch.key_byte0 <= rq.key0;
    req_ch.key_byte1 <= rq.key1;
    req_ch.key_byte2 <= rq.key2;
    req_ch.key_byte3 <= rq.key3;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_frame(rq);
  endtask

  function automatic frame_req_t random_request();
    frame_req_t rq;
    rq.req_type = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
    rq.sector   = 8'($urandom);
    rq.key0     = 8'($urandom);
    rq.key1     = 8'($urandom);
    rq.key2     = 8'($urandom);
    rq.key3     = 8'($urandom);
    return rq;
  endfunction

  task automatic wait_for_idle();
    req_ch.valid <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_module_address(input logic [7:0] addr);
    wait_for_idle();
    cfg_wdata <= addr;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    module_address_shadow = addr;
  endtask

  task automatic test_default_address();
    send_request('{REQ_READ, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
    send_request('{REQ_WRITE, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44});
  endtask

  task automatic test_field_extremes();
    set_module_address(8'h00);
    send_request('{REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_request('{REQ_READ, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    send_request('{REQ_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_request('{REQ_WRITE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    set_module_address(8'hff);
    send_request('{REQ_WRITE, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55});
    send_request('{REQ_READ, 8'haa, 8'h12, 8'h34, 8'h56, 8'h78});
    set_module_address(8'ha5);
    send_request('{REQ_WRITE, 8'h02, 8'hde, 8'had, 8'hbe, 8'hef});
    send_request('{REQ_READ, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00});
  endtask

  task automatic test_back_to_back();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_request(random_request());
    end
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      set_module_address(8'($urandom));
      tx_idle_en = (phase != 1) && (phase != 3);
      rx_idle_en = (phase != 2) && (phase != 3);
      for (int i = 0; i < 60; i++) begin
        send_request(random_request());
      end
    end
  endtask

  task automatic test_sink_backpressure();
    wait_for_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    sink_hold_cycles = 300;
    for (int i = 0; i < 20; i++) begin
      send_request(random_request());
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 8'h00;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_READ;
    req_ch.sector    <= 8'h00;
    req_ch.key_byte0 <= 8'h00;
    req_ch.key_byte1 <= 8'h00;
    req_ch.key_byte2 <= 8'h00;
    req_ch.key_byte3 <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_address();
    test_field_extremes();
    test_back_to_back();
    test_random_phases();
    test_sink_backpressure();

    wait_for_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
rtl/rcfb_pkg.sv
rtl/rcfb_if.sv
rtl/rcfb_ctrl.sv
rtl/rcfb_datapath.sv
rtl/rfid_command_frame_builder.sv
dv/rfid_command_frame_builder_tb.sv
